FILE: rtl/ott_pkg.sv
// ----------------------------------------------------------------------------
// ott_pkg
// Shared types and constants of the ordered timer table: operation and status
// codes, the stored slot entry and the result record.
// ----------------------------------------------------------------------------
package ott_pkg;

	localparam int unsigned MAX_RESULTS       = 16;
	localparam int unsigned KW                = $clog2(MAX_RESULTS + 1);
	localparam logic [31:0] DEFAULT_WINDOW_MS = 32'(60 * 60 * 1000);
	localparam logic [63:0] ALL_ONES          = ~64'd0;

	typedef enum logic [2:0] {
		OP_ADD     = 3'd0,
		OP_CANCEL  = 3'd1,
		OP_REFRESH = 3'd2,
		OP_RESET   = 3'd3,
		OP_EXPIRE  = 3'd4,
		OP_QUERY   = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_INACTIVE = 2'd1,
		STS_FULL     = 2'd2
	} status_t;

	// what one pass over the table looks for
	typedef enum logic [1:0] {
		SK_DUE     = 2'd0,
		SK_MIN_DUE = 2'd1,
		SK_MIN_ACT = 2'd2,
		SK_FRONT   = 2'd3
	} scan_kind_t;

	typedef struct packed {
		logic [63:0] deadline;
		logic [31:0] period;
		logic        repeat_mark;
	} slot_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  slot_id;
		logic [63:0] remaining_ms;
		logic        front_notify;
		logic        expired_valid;
		logic        last;
	} res_t;

	function automatic res_t mk_res(input status_t st, input logic [3:0] sid,
			input logic [63:0] rem, input logic fn, input logic ev, input logic lst);
		res_t r;
		r.status        = st;
		r.slot_id       = sid;
		r.remaining_ms  = rem;
		r.front_notify  = fn;
		r.expired_valid = ev;
		r.last          = lst;
		return r;
	endfunction

endpackage

FILE: rtl/ordered_timer_table_core.sv
// ----------------------------------------------------------------------------
// ordered_timer_table_core
// Table of timer slots ordered by deadline (lower slot wins a tie), with add,
// cancel, refresh, reset, expire and query operations.
// ----------------------------------------------------------------------------
// One operation is handled at a time. Slot contents live in a synchronous
// store with one write and one read port, read one slot per cycle during a
// pass over the table. Cancel, unused codes and operations that fail their
// first check go straight to the result; refresh reads and rewrites its slot;
// add writes a free slot and reset reads and may rewrite its slot, each write
// followed by a front check pass; query makes one pass. Expire takes one
// marking pass, then an ordering pass and a fire step per reported slot, with
// at most 16 reported slots per call. Each result transfer
// also waits for the output register to be free; the next operation is taken
// as soon as the last result has been loaded into it. Active marks are held in
// flops and cleared by reset; the store itself needs no clearing pass.
// ----------------------------------------------------------------------------
module ordered_timer_table_core
	import ott_pkg::*;
#(
	parameter int NUM_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  operation,
	input  logic [3:0]  timer_id,
	input  logic [31:0] interval_ms,
	input  logic        recurring,
	input  logic        restart,
	input  logic [63:0] now_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [3:0]  slot_id,
	output logic [63:0] remaining_ms,
	output logic        front_notify,
	output logic        expired_valid,
	output logic        last,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata
);

	localparam int IW = $clog2(NUM_SLOTS);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_UPD  = 6'b000010,
		S_ARM  = 6'b000100,
		S_SCAN = 6'b001000,
		S_FIRE = 6'b010000,
		S_EMIT = 6'b100000
	} state_t;

	state_t           state_q;
	logic [2:0]       op_q;
	logic [IW-1:0]    tgt_q;
	logic [31:0]      ivl_q;
	logic             rep_q;
	logic             fnow_q;
	logic [63:0]      now_q;
	logic [63:0]      base_q;
	logic [NUM_SLOTS-1:0] active_q;
	logic [NUM_SLOTS-1:0] due_q;
	logic [63:0]      prev_q;
	logic             fn_q;
	logic [31:0]      window_q;
	scan_kind_t       kind_q;
	logic [IW:0]      scan_q;
	logic             cmp_vld_s1;
	logic [IW-1:0]    cmp_idx_s1;
	logic             best_vld_q;
	logic [IW-1:0]    best_idx_q;
	logic [63:0]      best_dl_q;
	logic [31:0]      best_per_q;
	logic             best_rep_q;
	logic             blocked_q;
	logic             roll_q;
	logic [KW-1:0]    k_q;
	res_t             res_q;
	res_t             out_q;
	logic             out_valid_q;

	// store ports
	logic             mem_we;
	logic [IW-1:0]    mem_waddr;
	slot_t            mem_wdata;
	logic [IW-1:0]    mem_raddr;
	slot_t            rd;

	logic             accept;
	logic             out_free;
	logic [IW+3:0]    id_wide;
	logic [IW-1:0]    id_idx;
	logic             id_ok;
	logic             any_active;
	logic             free_found;
	logic [IW-1:0]    free_idx;
	logic             roll;
	logic             scan_done;
	logic [NUM_SLOTS-1:0] due_rest;
	logic             fire_last;
	logic [IW+3:0]    best_wide;
	logic [IW+3:0]    tgt_wide;
	logic             better;
	logic             front_fn;

	assign accept     = in_valid && !in_stall;
	assign in_stall   = (state_q != S_IDLE);
	assign out_free   = !out_valid_q || !out_stall;
	assign id_wide    = {{IW{1'b0}}, timer_id};
	assign id_idx     = id_wide[IW-1:0];
	assign id_ok      = (id_wide < (IW+4)'(NUM_SLOTS));
	assign any_active = |active_q;
	assign roll       = (now_ms < prev_q) && ((prev_q - now_ms) > {32'd0, window_q});
	assign scan_done  = (scan_q == (IW+1)'(NUM_SLOTS)) && !cmp_vld_s1;
	assign due_rest   = due_q & ~({{(NUM_SLOTS-1){1'b0}}, 1'b1} << best_idx_q);
	assign fire_last  = (k_q == KW'(MAX_RESULTS - 1)) || (due_rest == '0);
	assign best_wide  = {4'd0, best_idx_q};
	assign tgt_wide   = {4'd0, tgt_q};
	assign better     = !best_vld_q || (rd.deadline < best_dl_q);
	assign front_fn   = !blocked_q && !fn_q;

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_found = 1'b1;
				free_idx   = IW'(i);
			end
		end
	end

	// store access: id read on transfer, slot sweep during a pass
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = tgt_q;
		mem_wdata = '{deadline: base_q + {32'd0, ivl_q}, period: ivl_q, repeat_mark: rep_q};
		mem_raddr = (state_q == S_IDLE) ? id_idx : scan_q[IW-1:0];
		case (state_q)
			S_ARM: begin
				mem_we = 1'b1;
			end
			S_FIRE: begin
				mem_we    = best_rep_q;
				mem_waddr = best_idx_q;
				mem_wdata = '{deadline: now_q + {32'd0, best_per_q}, period: best_per_q,
					repeat_mark: 1'b1};
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	ott_slot_mem #(
		.DEPTH (NUM_SLOTS),
		.AW    (IW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= '0;
			tgt_q       <= '0;
			ivl_q       <= '0;
			rep_q       <= 1'b0;
			fnow_q      <= 1'b0;
			now_q       <= '0;
			base_q      <= '0;
			active_q    <= '0;
			due_q       <= '0;
			prev_q      <= '0;
			fn_q        <= 1'b0;
			window_q    <= DEFAULT_WINDOW_MS;
			kind_q      <= SK_DUE;
			scan_q      <= '0;
			cmp_vld_s1  <= 1'b0;
			cmp_idx_s1  <= '0;
			best_vld_q  <= 1'b0;
			best_idx_q  <= '0;
			best_dl_q   <= '0;
			best_per_q  <= '0;
			best_rep_q  <= 1'b0;
			blocked_q   <= 1'b0;
			roll_q      <= 1'b0;
			k_q         <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				window_q <= cfg_wdata;
			end
			// drop a result once it has been taken
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q   <= operation;
						ivl_q  <= interval_ms;
						fnow_q <= restart;
						now_q  <= now_ms;
						tgt_q  <= id_idx;
						state_q <= S_EMIT;
						case (operation)
							OP_ADD: begin
								if (!free_found) begin
									res_q <= mk_res(STS_FULL, 4'd0, 64'd0, 1'b0, 1'b0, 1'b1);
								end else begin
									tgt_q   <= free_idx;
									base_q  <= now_ms;
									rep_q   <= recurring;
									state_q <= S_ARM;
								end
							end
							OP_CANCEL: begin
								if (!id_ok || !active_q[id_idx]) begin
									res_q <= mk_res(STS_INACTIVE, 4'd0, 64'd0, 1'b0, 1'b0, 1'b1);
								end else begin
									active_q[id_idx] <= 1'b0;
									res_q <= mk_res(STS_OK, 4'd0, 64'd0, 1'b0, 1'b0, 1'b1);
								end
							end
							OP_REFRESH: begin
								if (!id_ok || !active_q[id_idx]) begin
									res_q <= mk_res(STS_INACTIVE, 4'd0, 64'd0, 1'b0, 1'b0, 1'b1);
								end else begin
									state_q <= S_UPD;
								end
							end
							OP_RESET: begin
								if (!id_ok) begin
									res_q <= mk_res(STS_INACTIVE, 4'd0, 64'd0, 1'b0, 1'b0, 1'b1);
								end else begin
									state_q <= S_UPD;
								end
							end
							OP_EXPIRE: begin
								if (!any_active) begin
									res_q <= mk_res(STS_OK, 4'd0, 64'd0, 1'b0, 1'b0, 1'b1);
								end else begin
									roll_q     <= roll;
									prev_q     <= now_ms;
									k_q        <= '0;
									kind_q     <= SK_DUE;
									scan_q     <= '0;
									best_vld_q <= 1'b0;
									state_q    <= S_SCAN;
								end
							end
							OP_QUERY: begin
								fn_q <= 1'b0;
								if (!any_active) begin
									res_q <= mk_res(STS_OK, 4'd0, ALL_ONES, 1'b0, 1'b0, 1'b1);
								end else begin
									kind_q     <= SK_MIN_ACT;
									scan_q     <= '0;
									best_vld_q <= 1'b0;
									state_q    <= S_SCAN;
								end
							end
							default: begin
								res_q <= mk_res(STS_OK, 4'd0, 64'd0, 1'b0, 1'b0, 1'b1);
							end
						endcase
					end
				end

				// store data of the addressed slot is on rd
				S_UPD: begin
					rep_q <= rd.repeat_mark;
					if (op_q == OP_REFRESH) begin
						base_q  <= now_q;
						ivl_q   <= rd.period;
						state_q <= S_ARM;
					end else if (ivl_q == rd.period && !fnow_q) begin
						res_q   <= mk_res(STS_OK, 4'd0, 64'd0, 1'b0, 1'b0, 1'b1);
						state_q <= S_EMIT;
					end else if (!active_q[tgt_q]) begin
						res_q   <= mk_res(STS_INACTIVE, 4'd0, 64'd0, 1'b0, 1'b0, 1'b1);
						state_q <= S_EMIT;
					end else begin
						base_q  <= fnow_q ? now_q : rd.deadline - {32'd0, rd.period};
						state_q <= S_ARM;
					end
				end

				// store written this cycle; base_q now keeps the new deadline
				S_ARM: begin
					active_q[tgt_q] <= 1'b1;
					base_q <= base_q + {32'd0, ivl_q};
					if (op_q == OP_REFRESH) begin
						res_q   <= mk_res(STS_OK, 4'd0, 64'd0, 1'b0, 1'b0, 1'b1);
						state_q <= S_EMIT;
					end else begin
						kind_q    <= SK_FRONT;
						scan_q    <= '0;
						blocked_q <= 1'b0;
						state_q   <= S_SCAN;
					end
				end

				S_SCAN: begin
					// issue one read a cycle, compare the slot read the cycle before
					if (scan_q < (IW+1)'(NUM_SLOTS)) begin
						cmp_vld_s1 <= 1'b1;
						cmp_idx_s1 <= scan_q[IW-1:0];
						scan_q     <= scan_q + 1'b1;
					end else begin
						cmp_vld_s1 <= 1'b0;
					end
					if (cmp_vld_s1) begin
						case (kind_q)
							SK_DUE: begin
								due_q[cmp_idx_s1] <= active_q[cmp_idx_s1] &&
									(roll_q || rd.deadline <= now_q);
							end
							SK_MIN_DUE, SK_MIN_ACT: begin
								if (((kind_q == SK_MIN_DUE) ? due_q[cmp_idx_s1]
										: active_q[cmp_idx_s1]) && better) begin
									best_vld_q <= 1'b1;
									best_idx_q <= cmp_idx_s1;
									best_dl_q  <= rd.deadline;
									best_per_q <= rd.period;
									best_rep_q <= rd.repeat_mark;
								end
							end
							SK_FRONT: begin
								if (cmp_idx_s1 != tgt_q && active_q[cmp_idx_s1] &&
										(rd.deadline < base_q ||
										(rd.deadline == base_q && cmp_idx_s1 < tgt_q))) begin
									blocked_q <= 1'b1;
								end
							end
							default: begin
								blocked_q <= blocked_q;
							end
						endcase
					end
					if (scan_done) begin
						state_q <= S_EMIT;
						case (kind_q)
							SK_DUE: begin
								if (due_q == '0) begin
									res_q <= mk_res(STS_OK, 4'd0, 64'd0, 1'b0, 1'b0, 1'b1);
								end else begin
									kind_q     <= SK_MIN_DUE;
									scan_q     <= '0;
									best_vld_q <= 1'b0;
									state_q    <= S_SCAN;
								end
							end
							SK_MIN_DUE: begin
								state_q <= S_FIRE;
							end
							SK_MIN_ACT: begin
								res_q <= mk_res(STS_OK, 4'd0,
									(now_q >= best_dl_q) ? 64'd0 : best_dl_q - now_q,
									1'b0, 1'b0, 1'b1);
							end
							default: begin
								if (front_fn) begin
									fn_q <= 1'b1;
								end
								res_q <= mk_res(STS_OK, (op_q == OP_ADD) ? tgt_wide[3:0] : 4'd0,
									64'd0, front_fn, 1'b0, 1'b1);
							end
						endcase
					end
				end

				// re-arm or free the earliest due slot and report it
				S_FIRE: begin
					if (!best_rep_q) begin
						active_q[best_idx_q] <= 1'b0;
					end
					due_q[best_idx_q] <= 1'b0;
					k_q   <= k_q + 1'b1;
					res_q <= mk_res(STS_OK, best_wide[3:0], 64'd0, 1'b0, 1'b1, fire_last);
					state_q <= S_EMIT;
				end

				S_EMIT: begin
					if (out_free) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						if (res_q.last) begin
							state_q <= S_IDLE;
						end else begin
							kind_q     <= SK_MIN_DUE;
							scan_q     <= '0;
							best_vld_q <= 1'b0;
							state_q    <= S_SCAN;
						end
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_q.status;
	assign slot_id       = out_q.slot_id;
	assign remaining_ms  = out_q.remaining_ms;
	assign front_notify  = out_q.front_notify;
	assign expired_valid = out_q.expired_valid;
	assign last          = out_q.last;

	// compare stage only runs behind a pass
	a_cmp_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_vld_s1 |-> state_q == S_SCAN)
		else $error("compare stage active outside a table pass");

	// a fired slot was marked due
	a_fire_due: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIRE |-> due_q[best_idx_q] && best_vld_q)
		else $error("firing a slot that is not due");

	// no more than the result limit per expire
	a_fire_limit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIRE |-> k_q < KW'(MAX_RESULTS))
		else $error("expire result limit exceeded");

	// an armed slot is active afterwards
	a_arm_active: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ARM |=> active_q[$past(tgt_q)])
		else $error("armed slot not active");

endmodule

FILE: rtl/ott_slot_mem.sv
// ----------------------------------------------------------------------------
// ott_slot_mem
// Slot store: deadline, period and recurring mark per slot. One write port,
// one read port, read data registered.
// ----------------------------------------------------------------------------
module ott_slot_mem
	import ott_pkg::*;
#(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  slot_t         wdata,
	input  logic [AW-1:0] raddr,
	output slot_t         rdata
);

	slot_t mem [DEPTH];
	slot_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule
